@@ rtl/masked_aes_inv_sbox_remask_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the masked inverse S-box and remask unit
// Concurrent assertions clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MASKED_AES_INV_SBOX_REMASK_ASSERT_SVH
`define MASKED_AES_INV_SBOX_REMASK_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MAISR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAISR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MAISR_ASSERT_NOW(lbl, ante, cons, msg)
`define MAISR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/maisr_pkg.sv @@
// ----------------------------------------------------------------------------
// maisr_pkg
// Types, constants and GF(2^8) helpers shared by the masked inverse S-box
// and column remask unit.
// ----------------------------------------------------------------------------
`default_nettype none

package maisr_pkg;

  // Operation carried with every column.
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_REMASK = 1'b1
  } opcode_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IN_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MASK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_MASK_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_MASK_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COL_MASK_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COL_MASK_D = 3'd5;

  localparam int unsigned NUM_LANES = 4;

  typedef logic [NUM_LANES-1:0][7:0] byte4_t;

  // Input transaction: one state column and its opcode.
  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
  } in_item_t;

  // Result transaction: one column.
  typedef struct packed {
    logic [7:0] out_zero;
    logic [7:0] out_one;
    logic [7:0] out_two;
    logic [7:0] out_three;
  } out_item_t;

  // Masks handed to each lane.
  typedef struct packed {
    logic [7:0] in_mask;
    logic [7:0] out_mask;
    logic [7:0] mix_mask;
  } lane_masks_t;

  // AES field reduction constant (x^8 + x^4 + x^3 + x + 1).
  localparam logic [7:0] GF_POLY = 8'h1b;

  // First row of the InvMixColumns matrix; later rows are rotations.
  localparam logic [3:0] INV_MIX_COEF [NUM_LANES] = '{4'he, 4'hb, 4'hd, 4'h9};

  // Standard AES inverse S-box.
  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] gf_xtime(input logic [7:0] v);
    gf_xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

  // Multiply by a 4-bit constant: shift and add over four bits.
  function automatic logic [7:0] gf_mul4(input logic [7:0] v, input logic [3:0] k);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = v;
    for (int b = 0; b < 4; b++) begin
      if (k[b]) begin
        acc = acc ^ p;
      end
      p = gf_xtime(p);
    end
    gf_mul4 = acc;
  endfunction

  // One output row of InvMixColumns applied to a column.
  function automatic logic [7:0] inv_mix_row(input byte4_t col, input logic [1:0] row);
    logic [7:0] acc;
    logic [1:0] sel;
    acc = 8'h00;
    for (int k = 0; k < NUM_LANES; k++) begin
      sel = 2'(k) - row;
      acc = acc ^ gf_mul4(col[k], INV_MIX_COEF[sel]);
    end
    inv_mix_row = acc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/maisr_lane.sv @@
// ----------------------------------------------------------------------------
// maisr_lane
// One byte lane: masked inverse S-box lookup or remask of a single row.
// ----------------------------------------------------------------------------
`default_nettype none

module maisr_lane
  import maisr_pkg::*;
(
  input  opcode_t     op,
  input  logic [7:0]  col_byte,
  input  lane_masks_t masks,
  output logic [7:0]  res_byte
);

  logic [7:0] sbox_idx;

  // Unmask the byte before the table, then apply the output mask.
  assign sbox_idx = col_byte ^ masks.in_mask;

  // Select the result of the requested operation.
  always_comb begin
    case (op)
      OP_LOOKUP: res_byte = INV_SBOX[sbox_idx] ^ masks.out_mask;
      OP_REMASK: res_byte = col_byte ^ masks.in_mask ^ masks.mix_mask;
      default:   res_byte = 8'h00;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/maisr_merge.sv @@
// ----------------------------------------------------------------------------
// maisr_merge
// Collects the four lane bytes into one result and holds it in the output
// register until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_aes_inv_sbox_remask_assert.svh"

module maisr_merge
  import maisr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  byte4_t    lane_res,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  logic      load;

  // The register may take a new column when empty or when being drained.
  assign load     = !out_valid_r || !out_stall;
  assign in_stall = !load;

  // Next state of the output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = in_fire;
      if (in_fire) begin
        out_data_nxt.out_zero  = lane_res[0];
        out_data_nxt.out_one   = lane_res[1];
        out_data_nxt.out_two   = lane_res[2];
        out_data_nxt.out_three = lane_res[3];
      end
    end
  end

  // Output register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted column is offered in the following cycle.
  `MAISR_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid, "accepted column not presented")

  // A held result is not dropped while the consumer stalls.
  `MAISR_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid, "stalled result lost")

  // Nothing appears without an accepted column or a held result.
  `MAISR_ASSERT_NEXT(a_no_spurious, !in_fire && !(out_valid && out_stall), !out_valid,
                     "result without a transaction")

  // A column is never taken while the register is full and stalled.
  `MAISR_ASSERT_NOW(a_no_overrun, out_valid && out_stall, !in_fire, "column accepted over held result")

endmodule

`default_nettype wire

@@ rtl/masked_aes_inv_sbox_remask.sv @@
// One state column of four bytes is accepted per clock cycle and its result appears
// in the output register in the next cycle; a column may follow in every cycle, the
// only wait being a stall from downstream while the output register is full. The
// four byte lanes work in parallel and the column mask for remask is formed by
// InvMixColumns logic straight from the mask registers, so a register written while
// the block is idle applies to the very next transaction. Mask writes are always
// taken; writes to an index beyond the last register are ignored.
// ----------------------------------------------------------------------------
// masked_aes_inv_sbox_remask
// Masked inverse S-box and column remask unit for masked AES decryption.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_aes_inv_sbox_remask
  import maisr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0]  in_mask_r;
  logic [7:0]  out_mask_r;
  byte4_t      col_mask_r;
  byte4_t      mix_mask;
  byte4_t      col_bytes;
  byte4_t      lane_res;
  logic        in_fire;

  // Mask registers; writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_mask_r  <= 8'h00;
      out_mask_r <= 8'h00;
      col_mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_MASK:    in_mask_r     <= cfg_data;
        REG_OUT_MASK:   out_mask_r    <= cfg_data;
        REG_COL_MASK_A: col_mask_r[0] <= cfg_data;
        REG_COL_MASK_B: col_mask_r[1] <= cfg_data;
        REG_COL_MASK_C: col_mask_r[2] <= cfg_data;
        REG_COL_MASK_D: col_mask_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake and column unpacking.
  assign in_fire      = in_valid && !in_stall;
  assign col_bytes[0] = in_data.byte_zero;
  assign col_bytes[1] = in_data.byte_one;
  assign col_bytes[2] = in_data.byte_two;
  assign col_bytes[3] = in_data.byte_three;

  // Byte lanes, each with its own row of the InvMixColumns column mask.
  for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
    lane_masks_t masks;

    assign mix_mask[j]    = inv_mix_row(col_mask_r, 2'(j));
    assign masks.in_mask  = in_mask_r;
    assign masks.out_mask = out_mask_r;
    assign masks.mix_mask = mix_mask[j];

    maisr_lane u_lane (
      .op       (in_data.opcode),
      .col_byte (col_bytes[j]),
      .masks    (masks),
      .res_byte (lane_res[j])
    );
  end

  // Merge the lane bytes into the output register.
  maisr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .lane_res  (lane_res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ sim/maisr_column_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// maisr_column_monitor
// Watches the column, result and mask write channels of the masked inverse
// S-box and remask unit. It keeps its own copy of the mask registers and
// predicts every result column. It then compares each result, row by row,
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module maisr_column_monitor
  import maisr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int         MAX_REPORTS  = 10;
  localparam logic [7:0] FIELD_POLY   = 8'h1b;
  localparam logic [7:0] AFFINE_CONST = 8'h05;
  // Top row of the InvMixColumns matrix; row r is this row rotated right by r.
  localparam logic [7:0] INV_MIX_BASE [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};

  logic [7:0] inv_sub [256];
  logic [7:0] in_mask_q;
  logic [7:0] out_mask_q;
  logic [7:0] col_mask_q [4];
  out_item_t  predicted_cols [$];

  // Full 8-bit multiply in GF(2^8).
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc ^= p;
      end
      p = {p[6:0], 1'b0} ^ (p[7] ? FIELD_POLY : 8'h00);
    end
    return acc;
  endfunction

  // Multiplicative inverse as x^254, which also maps zero to zero.
  function automatic logic [7:0] gf_invert(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] s;
    r = 8'h01;
    s = x;
    for (int i = 1; i < 8; i++) begin
      s = gf_times(s, s);
      r = gf_times(r, s);
    end
    return r;
  endfunction

  // One row of InvMixColumns applied to the four column mask bytes.
  function automatic logic [7:0] column_mask_row(input int row);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 4; k++) begin
      acc ^= gf_times(col_mask_q[k], INV_MIX_BASE[(k - row + 4) % 4]);
    end
    return acc;
  endfunction

  // Result column for one input column under the current masks.
  function automatic out_item_t predict_column(input in_item_t c);
    logic [7:0] rows_in [4];
    logic [7:0] rows_out [4];
    out_item_t  r;
    rows_in = '{c.byte_zero, c.byte_one, c.byte_two, c.byte_three};
    for (int j = 0; j < 4; j++) begin
      if (c.opcode == OP_REMASK) begin
        rows_out[j] = rows_in[j] ^ in_mask_q ^ column_mask_row(j);
      end else begin
        rows_out[j] = inv_sub[rows_in[j] ^ in_mask_q] ^ out_mask_q;
      end
    end
    r.out_zero  = rows_out[0];
    r.out_one   = rows_out[1];
    r.out_two   = rows_out[2];
    r.out_three = rows_out[3];
    return r;
  endfunction

  // The inverse S-box is built from the field inverse and the inverse affine map.
  initial begin : build_inv_sub
    logic [7:0] y;
    logic [7:0] t;
    for (int v = 0; v < 256; v++) begin
      y = 8'(v);
      t = {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]} ^ AFFINE_CONST;
      inv_sub[v] = gf_invert(t);
    end
  end

  // Results are checked before new columns are predicted, since a column
  // cannot produce its result at the edge where it is accepted.
  always @(posedge clk) begin
    out_item_t  want;
    logic [3:0] diff;
    if (!rst_n) begin
      in_mask_q   = 8'h00;
      out_mask_q  = 8'h00;
      col_mask_q  = '{8'h00, 8'h00, 8'h00, 8'h00};
      predicted_cols.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_cols.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%t: result transaction with nothing predicted: %h %h %h %h", $time,
                     out_data.out_zero, out_data.out_one, out_data.out_two,
                     out_data.out_three);
          end
        end else begin
          want = predicted_cols.pop_front();
          diff = {out_data.out_three != want.out_three, out_data.out_two != want.out_two,
                  out_data.out_one != want.out_one, out_data.out_zero != want.out_zero};
          if (diff != 4'b0000) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%t: column mismatch in rows %b (row 3..0): expected %h %h %h %h, got %h %h %h %h",
                       $time, diff, want.out_zero, want.out_one, want.out_two,
                       want.out_three, out_data.out_zero, out_data.out_one,
                       out_data.out_two, out_data.out_three);
            end
          end
        end
      end

      // Mask writes; indexes beyond the last register leave everything as it is.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IN_MASK:    in_mask_q     = cfg_data;
          REG_OUT_MASK:   out_mask_q    = cfg_data;
          REG_COL_MASK_A: col_mask_q[0] = cfg_data;
          REG_COL_MASK_B: col_mask_q[1] = cfg_data;
          REG_COL_MASK_C: col_mask_q[2] = cfg_data;
          REG_COL_MASK_D: col_mask_q[3] = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        predicted_cols.push_back(predict_column(in_data));
      end
      outstanding = predicted_cols.size();
    end
  end

endmodule

@@ sim/masked_aes_inv_sbox_remask_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_aes_inv_sbox_remask_tb
// Drives columns and mask writes into the masked inverse S-box and remask
// unit, and stalls the result side at random. A short directed section runs
// first, then random columns under a series of mask settings. The monitor
// beside the block predicts and checks every result.
// ----------------------------------------------------------------------------

module masked_aes_inv_sbox_remask_tb;
  import maisr_pkg::*;

  localparam int MAX_GAP        = 14;
  localparam int MASK_PHASES    = 11;
  localparam int RANDOM_COLUMNS = 1650;
  // Indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(REG_COL_MASK_D + 1);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(REG_COL_MASK_D + 2);

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  int                   mismatches;
  int                   outstanding;

  // Input side idling: stretches with random gaps alternate with quiet ones.
  int in_run_left = 0;
  bit in_quiet    = 1'b0;

  masked_aes_inv_sbox_remask DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  maisr_column_monitor u_monitor (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Timeout, many times the slowest correct run.
  initial begin
    #(10_000_000);
    $display("masked_aes_inv_sbox_remask_tb: done, errors");
    $finish;
  end

  // Result side: hold stall for a random gap before each transaction.
  initial begin
    int hold;
    int run_left;
    bit quiet;
    out_stall = 1'b1;
    run_left  = 0;
    quiet     = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (run_left == 0) begin
        quiet    = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(20, 80);
      end
      run_left--;
      hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_column(input opcode_t op, input logic [7:0] b0,
                                           input logic [7:0] b1, input logic [7:0] b2,
                                           input logic [7:0] b3);
    in_item_t c;
    c.opcode     = op;
    c.byte_zero  = b0;
    c.byte_one   = b1;
    c.byte_two   = b2;
    c.byte_three = b3;
    return c;
  endfunction

  // Present one column after a random gap and hold it until it is taken.
  task automatic send_column(input in_item_t col);
    int gap;
    if (in_run_left == 0) begin
      in_quiet    = ($urandom_range(0, 3) == 0);
      in_run_left = $urandom_range(20, 80);
    end
    in_run_left--;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= col;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_for_columns();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Write all six masks, then two unused indexes with random data.
  task automatic load_masks(input logic [7:0] im, input logic [7:0] om,
                            input logic [7:0] ca, input logic [7:0] cb,
                            input logic [7:0] cc, input logic [7:0] cd);
    logic [CFG_IDX_W-1:0] idx [8];
    logic [7:0]           val [8];
    idx = '{REG_IN_MASK, REG_OUT_MASK, REG_COL_MASK_A, REG_COL_MASK_B,
            REG_COL_MASK_C, REG_COL_MASK_D, REG_UNUSED_LO, REG_UNUSED_HI};
    val = '{im, om, ca, cb, cc, cd, 8'($urandom), 8'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Masks still at their reset value of zero.
    send_column(make_column(OP_LOOKUP, 8'h00, 8'hff, 8'h63, 8'h52));
    send_column(make_column(OP_LOOKUP, 8'hff, 8'h00, 8'h80, 8'h01));
    send_column(make_column(OP_REMASK, 8'h00, 8'hff, 8'h55, 8'haa));
    wait_for_columns();

    // Every mask at its top value.
    load_masks(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_column(make_column(OP_LOOKUP, 8'h00, 8'hff, 8'h0f, 8'hf0));
    send_column(make_column(OP_REMASK, 8'h00, 8'hff, 8'haa, 8'h55));
    send_column(make_column(OP_REMASK, 8'h01, 8'h02, 8'h04, 8'h80));
    wait_for_columns();

    // One column mask byte at a time, so each InvMixColumns coefficient shows alone.
    for (int k = 0; k < 4; k++) begin
      load_masks(8'h5a, 8'ha5, (k == 0) ? 8'h80 : 8'h00, (k == 1) ? 8'h80 : 8'h00,
                 (k == 2) ? 8'h80 : 8'h00, (k == 3) ? 8'h80 : 8'h00);
      send_column(make_column(OP_REMASK, 8'h00, 8'h00, 8'h00, 8'h00));
      send_column(make_column(OP_LOOKUP, 8'h5a, 8'ha5, 8'h00, 8'hff));
      wait_for_columns();
    end

    // Random columns under a new mask setting per phase, extremes first.
    for (int p = 0; p < MASK_PHASES; p++) begin
      case (p)
        0:       load_masks(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        1:       load_masks(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        default: load_masks(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                            pick_byte(), pick_byte());
      endcase
      repeat (RANDOM_COLUMNS / MASK_PHASES) begin
        send_column(make_column(opcode_t'(1'($urandom_range(0, 1))), pick_byte(),
                                pick_byte(), pick_byte(), pick_byte()));
      end
      wait_for_columns();
    end

    // Let any stray result show before the final verdict.
    repeat (4) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("masked_aes_inv_sbox_remask_tb: done, clean");
    end else begin
      $display("masked_aes_inv_sbox_remask_tb: done, errors");
    end
    $finish;
  end

endmodule
